// ===== hw/rtl/lrdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdi_pkg: shared types and constants of the diagonal interleaver
// Register indexes, field widths and the block descriptor that travels from
// the gathering front end through the block queue to the symbol back end.
// ----------------------------------------------------------------------------
package lrdi_pkg;

	// configuration register indexes
	localparam logic REG_SF = 1'b0;
	localparam logic REG_CR = 1'b1;

	// fixed field widths
	localparam int CW_W   = 8;   // codeword width
	localparam int SYM_W  = 12;  // symbol port width
	localparam int SF_W   = 4;
	localparam int CR_W   = 3;
	localparam int CFG_W  = 4;   // widest register

	// reset values and limits of the registers
	localparam logic [SF_W-1:0] SF_RESET = 4'd7;
	localparam logic [CR_W-1:0] CR_RESET = 3'd1;
	localparam logic [SF_W-1:0] SF_MIN   = 4'd6;
	localparam logic [CR_W-1:0] CR_MIN   = 3'd1;
	localparam logic [CR_W-1:0] CR_MAX   = 3'd4;

	// symbols per first block, and base symbols of a normal block
	localparam logic [3:0] FIRST_SYMS = 4'd8;
	localparam logic [3:0] BASE_SYMS  = 4'd4;

	// descriptor of one released block
	typedef struct packed {
		logic [SF_W-1:0] sf;     // effective spreading factor
		logic [3:0]      n;      // codewords per block
		logic [3:0]      p;      // symbols per block
		logic            first;  // first block of a frame
		logic            last;   // block closes the frame
	} blk_info_t;

	// front end to block queue write request
	typedef struct packed {
		logic      push;
		blk_info_t info;
	} blk_wr_t;

endpackage

// ===== hw/rtl/lora_diagonal_interleaver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lora_diagonal_interleaver_top: diagonal block interleaver
// Gathers codewords into blocks and emits the interleaved symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive codeword and frame_last with push; the item is
//   taken on a clock edge with push high and full low. One item per cycle.
//   Result queue side: while empty is low, symbol, block_last and
//   frame_done show the oldest symbol; pop takes it.
//   Configuration: cfg_write with cfg_index/cfg_data, only while idle; any
//   write drops a partial block and restarts the frame.
//   A block of n codewords (sf-2 in the first block, sf later) is released
//   on its last codeword or on frame_last and yields p symbols (8, or
//   4+coding_rate), one per cycle from the symbol back end while pop keeps
//   up. The releasing block goes through the block queue and the output
//   register before its first symbol is visible. The sustained input rate
//   is set by the back end's symbol walk; a two-block queue sits between.
//   full rises when both queue slots hold blocks, e.g. when pop stalls.
//   Reset: spreading_factor 7, coding_rate 1, empty buffer, first block.
// ----------------------------------------------------------------------------
module lora_diagonal_interleaver_top #(
	parameter int MAX_SF = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic                            cfg_index,
	input  logic [lrdi_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [lrdi_pkg::CW_W-1:0]       codeword,
	input  logic                            frame_last,
	output logic                            empty,
	input  logic                            pop,
	output logic [lrdi_pkg::SYM_W-1:0]      symbol,
	output logic                            block_last,
	output logic                            frame_done
);
	import lrdi_pkg::*;

	blk_wr_t                      wr;
	logic [MAX_SF-1:0][CW_W-1:0]  wr_data;
	logic                         q_full;
	logic                         rd_pop;
	logic                         head_valid;
	blk_info_t                    head_info;
	logic [MAX_SF-1:0][CW_W-1:0]  head_data;

	// gather codewords
	lrdi_front #(.MAX_SF(MAX_SF)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.codeword   (codeword),
		.frame_last (frame_last),
		.q_full     (q_full),
		.full       (full),
		.wr         (wr),
		.wr_data    (wr_data)
	);

	// hold released blocks
	lrdi_blkq #(.MAX_SF(MAX_SF)) u_blkq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.wr_data    (wr_data),
		.rd_pop     (rd_pop),
		.q_full     (q_full),
		.head_valid (head_valid),
		.head_info  (head_info),
		.head_data  (head_data)
	);

	// emit symbols
	lrdi_back #(.MAX_SF(MAX_SF)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_info  (head_info),
		.head_data  (head_data),
		.pop        (pop),
		.rd_pop     (rd_pop),
		.empty      (empty),
		.symbol     (symbol),
		.block_last (block_last),
		.frame_done (frame_done)
	);

endmodule

// ===== hw/rtl/lrdi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdi_front: codeword gathering front end
// Holds the configuration, collects codewords into the block buffer and
// hands each full or frame-closing block to the block queue.
// ----------------------------------------------------------------------------
module lrdi_front #(
	parameter int MAX_SF = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [lrdi_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                push,
	input  logic [lrdi_pkg::CW_W-1:0]           codeword,
	input  logic                                frame_last,
	input  logic                                q_full,
	output logic                                full,
	output lrdi_pkg::blk_wr_t                   wr,
	output logic [MAX_SF-1:0][lrdi_pkg::CW_W-1:0] wr_data
);
	import lrdi_pkg::*;

	localparam int IW = $clog2(MAX_SF);
	localparam int FW = $clog2(MAX_SF + 1);

	logic [SF_W-1:0]              sf_q;
	logic [CR_W-1:0]              cr_q;
	logic [MAX_SF-1:0][CW_W-1:0]  buf_q;
	logic [FW-1:0]                fill_q;
	logic                         first_q;

	logic [SF_W-1:0]              sf_eff;
	logic [CR_W-1:0]              cr_eff;
	logic [3:0]                   n;
	logic [3:0]                   p;
	logic                         accept;
	logic                         done;
	logic [MAX_SF-1:0][CW_W-1:0]  buf_nx;

	// clamp the registers to their usable range
	always_comb begin
		if (sf_q < SF_MIN) begin
			sf_eff = SF_MIN;
		end else if (sf_q > SF_W'(MAX_SF)) begin
			sf_eff = SF_W'(MAX_SF);
		end else begin
			sf_eff = sf_q;
		end
		if (cr_q < CR_MIN) begin
			cr_eff = CR_MIN;
		end else if (cr_q > CR_MAX) begin
			cr_eff = CR_MAX;
		end else begin
			cr_eff = cr_q;
		end
	end

	// block geometry of the block being gathered
	assign n = first_q ? (sf_eff - 4'd2) : sf_eff;
	assign p = first_q ? FIRST_SYMS : (BASE_SYMS + 4'(cr_eff));

	assign accept = push && !q_full;
	assign full   = q_full;

	// insert the new codeword and decide on release
	always_comb begin
		buf_nx = buf_q;
		if (fill_q < FW'(MAX_SF)) begin
			buf_nx[fill_q[IW-1:0]] = codeword;
		end
		done = ((5'(fill_q) + 5'd1) >= 5'(n)) || frame_last;
	end

	assign wr.push       = accept && done;
	assign wr.info.sf    = sf_eff;
	assign wr.info.n     = n;
	assign wr.info.p     = p;
	assign wr.info.first = first_q;
	assign wr.info.last  = frame_last;
	assign wr_data       = buf_nx;

	// configuration and gathering state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q    <= SF_RESET;
			cr_q    <= CR_RESET;
			buf_q   <= '0;
			fill_q  <= '0;
			first_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SF: sf_q <= cfg_data;
				REG_CR: cr_q <= cfg_data[CR_W-1:0];
				default: ;
			endcase
			// drop any partial block and restart the frame
			buf_q   <= '0;
			fill_q  <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (done) begin
				buf_q   <= '0;
				fill_q  <= '0;
				first_q <= frame_last;
			end else begin
				buf_q  <= buf_nx;
				fill_q <= fill_q + FW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/lrdi_blkq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdi_blkq: two-entry block queue
// Decouples block gathering from symbol generation; each entry carries a
// whole block snapshot and its descriptor.
// ----------------------------------------------------------------------------
module lrdi_blkq #(
	parameter int MAX_SF = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lrdi_pkg::blk_wr_t                     wr,
	input  logic [MAX_SF-1:0][lrdi_pkg::CW_W-1:0] wr_data,
	input  logic                                  rd_pop,
	output logic                                  q_full,
	output logic                                  head_valid,
	output lrdi_pkg::blk_info_t                   head_info,
	output logic [MAX_SF-1:0][lrdi_pkg::CW_W-1:0] head_data
);
	import lrdi_pkg::*;

	blk_info_t                    info_q [2];
	logic [MAX_SF-1:0][CW_W-1:0]  data_q [2];
	logic                         wp_q;
	logic                         rp_q;
	logic [1:0]                   cnt_q;

	assign q_full     = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_info  = info_q[rp_q];
	assign head_data  = data_q[rp_q];

	// store blocks at the write pointer
	always_ff @(posedge clk) begin
		if (wr.push) begin
			info_q[wp_q] <= wr.info;
			data_q[wp_q] <= wr_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr.push) begin
				wp_q <= ~wp_q;
			end
			if (rd_pop) begin
				rp_q <= ~rp_q;
			end
			case ({wr.push, rd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("block queue occupancy out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.push && q_full)) else $error("block pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pop |-> head_valid) else $error("block popped from empty queue");

endmodule

// ===== hw/rtl/lrdi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdi_back: symbol generation back end
// Walks the head block one symbol per cycle unless stalled by pop, rotating
// the selected bit column diagonally; the output register holds each symbol.
// ----------------------------------------------------------------------------
module lrdi_back #(
	parameter int MAX_SF = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  head_valid,
	input  lrdi_pkg::blk_info_t                   head_info,
	input  logic [MAX_SF-1:0][lrdi_pkg::CW_W-1:0] head_data,
	input  logic                                  pop,
	output logic                                  rd_pop,
	output logic                                  empty,
	output logic [lrdi_pkg::SYM_W-1:0]            symbol,
	output logic                                  block_last,
	output logic                                  frame_done
);
	import lrdi_pkg::*;

	localparam int IW = $clog2(MAX_SF);

	logic [2:0]        idx_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  symbol_q;
	logic              block_last_q;
	logic              frame_done_q;

	logic              advance;
	logic              sym_last;
	logic [2:0]        src;
	logic [MAX_SF-1:0] col;
	logic [3:0]        im;
	logic [4:0]        t;
	logic [SYM_W-1:0]  sym;
	logic [3:0]        pos;

	assign advance  = head_valid && (!out_valid_q || pop);
	assign sym_last = ({1'b0, idx_q} == (head_info.p - 4'd1));
	assign rd_pop   = advance && sym_last;

	// build the current symbol from the bit column of the head block
	always_comb begin
		src = 3'(head_info.p - 4'd1 - {1'b0, idx_q});
		for (int k = 0; k < MAX_SF; k++) begin
			col[k] = head_data[k][src];
		end
		im  = ({1'b0, idx_q} >= head_info.n) ? ({1'b0, idx_q} - head_info.n)
			: {1'b0, idx_q};
		sym = '0;
		t   = '0;
		pos = '0;
		for (int j = 0; j < MAX_SF; j++) begin
			if (4'(j) < head_info.n) begin
				t = 5'(im) + 5'(head_info.n) - 5'(j) - 5'd1;
				if (t >= 5'(head_info.n)) begin
					t = t - 5'(head_info.n);
				end
				pos = head_info.sf - 4'd1 - 4'(j);
				sym[pos] = col[t[IW-1:0]];
			end
		end
		// first block ORs the XOR of all symbol bits into bit 1
		if (head_info.first) begin
			sym[1] = sym[1] | (^sym);
		end
	end

	// symbol index within the head block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= sym_last ? 3'd0 : (idx_q + 3'd1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance) begin
			symbol_q     <= sym;
			block_last_q <= sym_last;
			frame_done_q <= sym_last && head_info.last;
		end
	end

	assign empty      = !out_valid_q;
	assign symbol     = symbol_q;
	assign block_last = block_last_q;
	assign frame_done = frame_done_q;

	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> head_valid) else $error("block left while mid-way");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < head_info.p))
		else $error("symbol index beyond block");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_done_q) |-> block_last_q)
		else $error("frame end not on block end");

endmodule
